/* sv/lkv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, operation codes and the compare-unit result type shared by
// the cache sequencer, its compare unit and the port checker.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] SET_VALUE  = 32'h0000_0000;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  // Outcome of one pass through the shared compare unit.
  typedef struct packed {
    logic key_eq;   // stored key equals the request key
    logic rank_eq;  // stored rank equals the threshold
    logic rank_lt;  // stored rank is below the threshold
  } cmp_res_t;

endpackage

/* sv/lkv_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache entry memory
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/lkv_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache compare unit
// The one key and rank comparator, reused for every entry the sequencer
// sweeps through.
// ----------------------------------------------------------------------------
module lkv_cmp #(
  parameter int unsigned IW = 4,
  parameter int unsigned CW = 5
) (
  input  logic [lkv_pkg::KEY_W-1:0] key_a,
  input  logic [lkv_pkg::KEY_W-1:0] key_b,
  input  logic [IW-1:0]             rank,
  input  logic [CW-1:0]             thr,
  output lkv_pkg::cmp_res_t         res
);

  import lkv_pkg::*;

  logic [CW-1:0] rank_ext;

  assign rank_ext    = CW'(rank);
  assign res.key_eq  = (key_a == key_b);
  assign res.rank_eq = (rank_ext == thr);
  assign res.rank_lt = (rank_ext < thr);

endmodule

/* sv/lru_key_value_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache
// Associative key-value store that keeps its entries in recency order. A get
// returns the value of a present key, a set updates or inserts, evicting the
// least recently used entry when the configured capacity is reached.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_ready  in_mode, in_lookup_key, in_write_value
//   out      output     out_valid/out_ready out_hit, out_read_value
//   cfg      input      cfg_wr_en          cfg_wr_data (capacity in use)
//
// A request walks the filled entries one entry per cycle, through the single
// compare unit and the one read port of the rank memory, once to search and
// once to re-rank (a get that misses skips the re-rank).
// A synchronous reset empties the cache at once; no clearing pass is needed.
// in_ready is high only while no request is in flight; a finished result
// waits in the output register, and a new request is taken meanwhile.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [lkv_pkg::KEY_W-1:0]       in_lookup_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_write_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  input  logic                            cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]       cfg_wr_data
);

  import lkv_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPD,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             pv_r, pv_nxt;
  logic [IW-1:0]    pidx_r, pidx_nxt;
  logic             hit_r, hit_nxt;
  logic [IW-1:0]    found_r, found_nxt;
  logic [IW-1:0]    frank_r, frank_nxt;
  logic [IW-1:0]    victim_r, victim_nxt;
  logic [IW-1:0]    tgt_r, tgt_nxt;
  logic [CW-1:0]    thr_r, thr_nxt;
  logic             append_r, append_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             res_hit_r, res_hit_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;

  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [IW-1:0]    rank_rd;
  logic [CW-1:0]    cmp_thr;
  cmp_res_t         cmp;
  logic             issue;
  logic             last;
  logic             room;
  logic             rank_we;
  logic [IW-1:0]    rank_waddr;
  logic [IW-1:0]    rank_wdata;
  logic             entry_we;
  logic [IW-1:0]    raddr;

  assign issue = (idx_r < fill_r);
  assign last  = pv_r && (CW'(pidx_r) == (fill_r - CW'(1)));
  assign raddr = idx_r[IW-1:0];

  // Room for a new entry: below both the memory size and the capacity in
  // use, where a capacity of zero counts as one.
  assign room = (fill_r != FULL) &&
                ((cap_r == '0) ? (fill_r == '0) : (EW'(fill_r) < EW'(cap_r)));

  assign cmp_thr = (state_r == ST_SCAN) ? (fill_r - CW'(1)) : thr_r;

  lkv_cmp #(
    .IW (IW),
    .CW (CW)
  ) u_cmp (
    .key_a (key_r),
    .key_b (key_rd),
    .rank  (rank_rd),
    .thr   (cmp_thr),
    .res   (cmp)
  );

  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = tgt_r;
    rank_wdata = '0;
    if (state_r == ST_UPD && pv_r) begin
      rank_we    = 1'b1;
      rank_waddr = pidx_r;
      if (pidx_r == tgt_r) begin
        rank_wdata = '0;
      end else if (cmp.rank_lt) begin
        rank_wdata = rank_rd + IW'(1);
      end else begin
        rank_wdata = rank_rd;
      end
    end else if (state_r == ST_FIN && append_r) begin
      rank_we = 1'b1;
    end
  end

  assign entry_we = (state_r == ST_FIN) && (mode_r == MODE_SET);

  lkv_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_key_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (tgt_r),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (key_rd)
  );

  lkv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_val_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (tgt_r),
    .wdata (val_r),
    .raddr (found_r),
    .rdata (val_rd)
  );

  lkv_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (raddr),
    .rdata (rank_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    frank_nxt     = frank_r;
    victim_nxt    = victim_r;
    tgt_nxt       = tgt_r;
    thr_nxt       = thr_r;
    append_nxt    = append_r;
    fill_nxt      = fill_r;
    cap_nxt       = cfg_wr_en ? cfg_wr_data : cap_r;
    res_hit_nxt   = res_hit_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    out_val_nxt   = out_val_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          key_nxt    = in_lookup_key;
          val_nxt    = in_write_value;
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
          found_nxt  = '0;
          frank_nxt  = '0;
          victim_nxt = '0;
          append_nxt = 1'b0;
          state_nxt  = (fill_r == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads run one entry ahead of the compare.
        if (issue) begin
          idx_nxt  = idx_r + CW'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[IW-1:0];
        end
        if (pv_r) begin
          if (cmp.key_eq && !hit_r) begin
            hit_nxt   = 1'b1;
            found_nxt = pidx_r;
            frank_nxt = rank_rd;
          end
          if (cmp.rank_eq) begin
            victim_nxt = pidx_r;
          end
        end
        if (last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        idx_nxt = '0;
        if (hit_r) begin
          tgt_nxt   = found_r;
          thr_nxt   = CW'(frank_r);
          state_nxt = ST_UPD;
        end else if (mode_r == MODE_GET) begin
          state_nxt = ST_FIN;
        end else if (room) begin
          // New entry in the next free slot; every filled entry ages by one.
          tgt_nxt    = fill_r[IW-1:0];
          thr_nxt    = fill_r;
          append_nxt = 1'b1;
          state_nxt  = (fill_r == '0) ? ST_FIN : ST_UPD;
        end else begin
          tgt_nxt   = victim_r;
          thr_nxt   = fill_r - CW'(1);
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (issue) begin
          idx_nxt  = idx_r + CW'(1);
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[IW-1:0];
        end
        if (last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        res_hit_nxt = hit_r;
        if (mode_r == MODE_SET) begin
          res_val_nxt = SET_VALUE;
        end else if (hit_r) begin
          res_val_nxt = val_rd;
        end else begin
          res_val_nxt = MISS_VALUE;
        end
        if (append_r) begin
          fill_nxt = fill_r + CW'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_val_nxt   = res_val_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pv_r        <= 1'b0;
      fill_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    pidx_r    <= pidx_nxt;
    hit_r     <= hit_nxt;
    found_r   <= found_nxt;
    frank_r   <= frank_nxt;
    victim_r  <= victim_nxt;
    tgt_r     <= tgt_nxt;
    thr_r     <= thr_nxt;
    append_r  <= append_nxt;
    res_hit_r <= res_hit_nxt;
    res_val_r <= res_val_nxt;
    out_hit_r <= out_hit_nxt;
    out_val_r <= out_val_nxt;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;

endmodule

/* sv/lkv_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache port checker
// Watches the ports of the cache over time and flags results or handshakes
// that cannot occur.
// ----------------------------------------------------------------------------
module lkv_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_hit,
  input logic signed [lkv_pkg::VAL_W-1:0] out_read_value
);

  import lkv_pkg::*;

  // A result held back by the consumer keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_read_value))
    else $error("result changed while stalled");

  // A taken request keeps the cache busy, so in_ready drops after each accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready |=> !in_ready)
    else $error("request taken on back-to-back cycles");

  // Only a get that hits returns a value other than the miss and set codes.
  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_read_value != SET_VALUE) && (out_read_value != MISS_VALUE)
      |-> out_hit)
    else $error("stored value returned without a hit");

  // A miss reports either the set code or the miss code.
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_hit |->
      (out_read_value == SET_VALUE) || (out_read_value == MISS_VALUE))
    else $error("miss carries a stored value");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
      !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind lru_key_value_cache lkv_check u_lkv_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hit        (out_hit),
  .out_read_value (out_read_value)
);

/* tb/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Sends get and set requests through the valid/ready request channel and
// checks every reply against a behavioral recency-ordered store in the bench
// or a hand-picked typed reply. Hand-picked requests come first, then random
// phases at several capacities, with idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned PHASE_COUNT    = 11;
  localparam int unsigned PHASE_REQUESTS = 170;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DIRECTED_COUNT = 25;

  localparam logic [KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } cache_reply_t;

  // One hand-picked request, with an optional capacity write ahead of it.
  typedef struct packed {
    logic             wr_cap;
    logic [CAP_W-1:0] cap;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    logic             exp_hit;
    logic [VAL_W-1:0] exp_value;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{1'b0, 5'd0,  MODE_GET, 31'd0,         32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
    '{1'b0, 5'd0,  MODE_SET, KEY_MAX,       32'h8000_0000, 1'b1, 1'b0, SET_VALUE},
    '{1'b0, 5'd0,  MODE_GET, KEY_MAX,       32'h1234_5678, 1'b1, 1'b1, 32'h8000_0000},
    '{1'b0, 5'd0,  MODE_SET, 31'd0,         32'h7FFF_FFFF, 1'b1, 1'b0, SET_VALUE},
    '{1'b0, 5'd0,  MODE_GET, 31'd0,         32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, 5'd0,  MODE_SET, 31'd0,         32'hFFFF_FFFF, 1'b1, 1'b1, SET_VALUE},
    '{1'b0, 5'd0,  MODE_GET, 31'd0,         32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, 5'd0,  MODE_SET, 31'd5,         32'h0000_0000, 1'b1, 1'b0, SET_VALUE},
    '{1'b0, 5'd0,  MODE_GET, 31'h7FFF_FFFE, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
    // Capacity drops below the fill level: new keys evict without shrinking.
    '{1'b1, 5'd2,  MODE_SET, 31'd9,         32'd123,       1'b1, 1'b0, SET_VALUE},
    '{1'b0, 5'd0,  MODE_GET, KEY_MAX,       32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  MODE_GET, 31'd0,         32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // A capacity of zero behaves as one.
    '{1'b1, 5'd0,  MODE_SET, 31'd77,        32'd1,         1'b1, 1'b0, SET_VALUE},
    '{1'b0, 5'd0,  MODE_GET, 31'd5,         32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  MODE_GET, 31'd77,        32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  MODE_GET, 31'd9,         32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // Capacities above the table size behave as the table size.
    '{1'b1, 5'd31, MODE_SET, 31'd100,       32'd2,         1'b1, 1'b0, SET_VALUE},
    '{1'b0, 5'd0,  MODE_SET, 31'd101,       32'd3,         1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  MODE_GET, 31'd77,        32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b1, 5'd17, MODE_SET, 31'd0,         32'h5555_5555, 1'b0, 1'b0, 32'h0},
    '{1'b1, 5'd1,  MODE_SET, 31'd200,       32'd7,         1'b1, 1'b0, SET_VALUE},
    '{1'b0, 5'd0,  MODE_GET, 31'd200,       32'h0000_0000, 1'b1, 1'b1, 32'd7},
    '{1'b0, 5'd0,  MODE_GET, 31'd100,       32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b1, 5'd16, MODE_SET, KEY_MAX,       32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 5'd0,  MODE_GET, KEY_MAX,       32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  localparam logic [CAP_W-1:0] PHASE_CAPS [PHASE_COUNT] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd3, 5'd12, 5'd8, 5'd16
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_mode;
  logic [KEY_W-1:0]        in_lookup_key;
  logic signed [VAL_W-1:0] in_write_value;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_hit;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    cfg_wr_en;
  logic [CAP_W-1:0]        cfg_wr_data;

  lru_key_value_cache #(
    .MAX_ENTRIES(DEPTH)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_lookup_key (in_lookup_key),
    .in_write_value(in_write_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // Shadow copy of the cache contents and recency order.
  logic [KEY_W-1:0] shadow_key  [DEPTH];
  logic [VAL_W-1:0] shadow_value[DEPTH];
  int unsigned      shadow_rank [DEPTH];
  int unsigned      shadow_fill = 0;
  logic [CAP_W-1:0] shadow_cap  = CAP_RESET;

  cache_reply_t pending_replies[$];
  logic         cur_typed;
  cache_reply_t cur_typed_reply;
  bit           gaps_on = 1'b1;
  int unsigned  error_count   = 0;
  int unsigned  request_count = 0;
  int unsigned  reply_count   = 0;
  int unsigned  get_hit_count = 0;
  int unsigned  evict_count   = 0;
  int unsigned  quiet_cycles  = 0;

  function automatic void make_most_recent(input int unsigned slot);
    int unsigned r;
    int unsigned i;
    r = shadow_rank[slot];
    for (i = 0; i < shadow_fill; i++) begin
      if (shadow_rank[i] < r) begin
        shadow_rank[i] = shadow_rank[i] + 1;
      end
    end
    shadow_rank[slot] = 0;
  endfunction

  function automatic cache_reply_t apply_request(input logic mode,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [VAL_W-1:0] value);
    cache_reply_t reply;
    int unsigned  slot;
    int unsigned  limit;
    int unsigned  i;
    bit           found;
    found = 1'b0;
    slot  = 0;
    for (i = 0; i < shadow_fill; i++) begin
      if (!found && shadow_key[i] == key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    limit = (shadow_cap == 0) ? 1 : ((shadow_cap > DEPTH) ? DEPTH : shadow_cap);
    reply.hit   = found;
    reply.value = SET_VALUE;
    if (mode == MODE_GET) begin
      if (found) begin
        reply.value = shadow_value[slot];
        make_most_recent(slot);
      end else begin
        reply.value = MISS_VALUE;
      end
    end else if (found) begin
      shadow_value[slot] = value;
      make_most_recent(slot);
    end else if (shadow_fill < limit) begin
      for (i = 0; i < shadow_fill; i++) begin
        shadow_rank[i] = shadow_rank[i] + 1;
      end
      shadow_key[shadow_fill]   = key;
      shadow_value[shadow_fill] = value;
      shadow_rank[shadow_fill]  = 0;
      shadow_fill = shadow_fill + 1;
    end else begin
      // Full (or over a lowered capacity): reuse the least recent slot.
      for (i = 0; i < shadow_fill; i++) begin
        if (shadow_rank[i] == shadow_fill - 1) begin
          slot = i;
        end
      end
      shadow_key[slot]   = key;
      shadow_value[slot] = value;
      make_most_recent(slot);
      evict_count = evict_count + 1;
    end
    return reply;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    case ($urandom_range(0, 3))
      0:       key = KEY_W'($urandom_range(0, 31));
      1:       key = KEY_MAX - KEY_W'($urandom_range(0, 31));
      default: key = KEY_W'($urandom());
    endcase
    return key;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    logic [VAL_W-1:0] value;
    case ($urandom_range(0, 9))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7FFF_FFFF;
      2:       value = 32'hFFFF_FFFF;
      3:       value = 32'h0000_0000;
      default: value = $urandom();
    endcase
    return value;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Replies are checked before new requests are logged, all at the rising edge.
  always @(posedge clk) begin
    cache_reply_t want;
    cache_reply_t predicted;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        reply_count = reply_count + 1;
        if (pending_replies.size() == 0) begin
          $display("%0t: reply with no request outstanding, got hit %0b value %0d",
                   $time, out_hit, out_read_value);
          error_count = error_count + 1;
        end else begin
          want = pending_replies.pop_front();
          if (out_hit !== want.hit) begin
            $display("%0t: hit mismatch, expected %0b, actual %0b",
                     $time, want.hit, out_hit);
            error_count = error_count + 1;
          end
          if (out_read_value !== $signed(want.value)) begin
            $display("%0t: read_value mismatch, expected %0d, actual %0d",
                     $time, $signed(want.value), out_read_value);
            error_count = error_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        request_count = request_count + 1;
        predicted = apply_request(in_mode, in_lookup_key, in_write_value);
        if (in_mode == MODE_GET && predicted.hit) begin
          get_hit_count = get_hit_count + 1;
        end
        pending_replies.push_back(cur_typed ? cur_typed_reply : predicted);
      end
      if (cfg_wr_en) begin
        shadow_cap = cfg_wr_data;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("lru_key_value_cache_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reply side: random stall bursts while gaps are enabled.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Presents one request and returns at the edge where it is taken.
  task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value, input logic typed,
                              input cache_reply_t typed_reply);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cur_typed       = typed;
    cur_typed_reply = typed_reply;
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_lookup_key  <= key;
    in_write_value <= value;
    do begin
      @(posedge clk);
    end while (!(in_valid && in_ready));
  endtask

  // The capacity only changes with no request in flight.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0] key_pool[$];
    directed_row_t    row;
    cache_reply_t     typed_reply;
    cache_reply_t     no_reply;
    int unsigned      pool_size;
    int unsigned      p;
    int unsigned      n;
    logic             mode;
    logic [KEY_W-1:0] key;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_GET;
    in_lookup_key  = '0;
    in_write_value = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    cur_typed      = 1'b0;
    no_reply       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIRECTED_COUNT; n++) begin
      row = DIRECTED_ROWS[n];
      if (row.wr_cap) begin
        write_capacity(row.cap);
      end
      typed_reply.hit   = row.exp_hit;
      typed_reply.value = row.exp_value;
      send_request(row.mode, row.key, row.value, row.typed, typed_reply);
    end

    // Random phases: most keys come from a small pool sized near the
    // capacity, so hits, updates and evictions all occur often.
    for (p = 0; p < PHASE_COUNT; p++) begin
      write_capacity(PHASE_CAPS[p]);
      gaps_on = (p == PHASE_COUNT - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      key_pool.delete();
      pool_size = ((PHASE_CAPS[p] == 0) ? 1 :
                   (PHASE_CAPS[p] > DEPTH) ? DEPTH : PHASE_CAPS[p]) + $urandom_range(1, 6);
      for (n = 0; n < pool_size; n++) begin
        key_pool.push_back(random_key());
      end
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        mode = $urandom_range(0, 1) ? MODE_SET : MODE_GET;
        key  = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_size - 1)]
                                           : random_key();
        send_request(mode, key, random_value(), 1'b0, no_reply);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);

    $display("summary: %0d requests, %0d replies, %0d get hits, %0d evictions,",
             request_count, reply_count, get_hit_count, evict_count);
    $display("summary: capacities 0, 1, 2, 3, 5, 8, 12, 16, 17 and 31 exercised");
    if (error_count == 0) begin
      $display("lru_key_value_cache_tb: clean");
    end else begin
      $display("lru_key_value_cache_tb: errors");
    end
    $finish;
  end

endmodule
